/* sv/pfp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfp_pkg
// Shared constants and width helpers for the plane-from-three-points core.
// ----------------------------------------------------------------------------
package pfp_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned NORMAL_FRAC_DEF = 30;
  localparam int unsigned CFG_WIDTH       = 64;
  localparam int unsigned LANES           = 3;

  // magnitude of one cross-product component
  function automatic int unsigned mag_width(int unsigned cw);
    return 2 * (cw + 1);
  endfunction

  // squared length of the cross product (sum of three squares)
  function automatic int unsigned sum_width(int unsigned cw);
    return 4 * (cw + 1) + 2;
  endfunction

endpackage

/* sv/plane_from_three_points_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plane_from_three_points_core
// Plane through three points: exact cross product, rounded unit normal in
// signed Q2.F and plane offset d in the coordinate format.
//
//   channel  signals                              direction
//   cfg      cfg_valid_i/cfg_ready_o, 64b data    in   (collinearity threshold)
//   in       in_valid_i/in_ready_o, p1..p3 xyz    in   (one request per triangle)
//   out      out_valid_o/out_ready_i, n, d, flag  out  (one result per request)
//
// The pipeline has 8 cross-product stages, 2F+3 division stages and F+2
// square-root stages of the normal unit, one rounding stage, and 5 offset
// stages ending in the output register. One request is accepted every
// cycle while the output register is empty or its result is taken.
// When the output register holds a result that is not taken, the whole
// pipeline holds and in_ready_o drops. Reset clears the valid bits and the
// threshold; the configuration port is always ready.
// ----------------------------------------------------------------------------
module plane_from_three_points_core #(
  parameter int unsigned COORD_WIDTH      = pfp_pkg::COORD_WIDTH_DEF,
  parameter int unsigned NORMAL_FRAC_BITS = pfp_pkg::NORMAL_FRAC_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [pfp_pkg::CFG_WIDTH-1:0]          cfg_min_len_sq_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]          p1_x_i,
  input  logic signed [COORD_WIDTH-1:0]          p1_y_i,
  input  logic signed [COORD_WIDTH-1:0]          p1_z_i,
  input  logic signed [COORD_WIDTH-1:0]          p2_x_i,
  input  logic signed [COORD_WIDTH-1:0]          p2_y_i,
  input  logic signed [COORD_WIDTH-1:0]          p2_z_i,
  input  logic signed [COORD_WIDTH-1:0]          p3_x_i,
  input  logic signed [COORD_WIDTH-1:0]          p3_y_i,
  input  logic signed [COORD_WIDTH-1:0]          p3_z_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [NORMAL_FRAC_BITS+1:0]     normal_x_o,
  output logic signed [NORMAL_FRAC_BITS+1:0]     normal_y_o,
  output logic signed [NORMAL_FRAC_BITS+1:0]     normal_z_o,
  output logic signed [COORD_WIDTH:0]            offset_d_o,
  output logic                                   collinear_o
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned F  = NORMAL_FRAC_BITS;
  localparam int unsigned QW = 2 * pfp_pkg::mag_width(CW);
  localparam int unsigned SW = pfp_pkg::sum_width(CW);

  logic [pfp_pkg::CFG_WIDTH-1:0] min_len_sq_q;
  logic                          adv;

  logic                 x_valid, x_coll;
  logic [2:0][QW-1:0]   x_sq;
  logic [2:0]           x_cneg;
  logic [SW-1:0]        x_s;
  logic [2:0][CW-1:0]   x_p3;

  logic                 u_valid, u_coll;
  logic [2:0][F+1:0]    u_n;
  logic [2:0][CW-1:0]   u_p3;

  logic [2:0][F+1:0]    o_n;
  logic [CW:0]          o_d;

  // hold the threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_sq_q <= '0;
    end else if (cfg_valid_i) begin
      min_len_sq_q <= cfg_min_len_sq_i;
    end
  end
  assign cfg_ready_o = 1'b1;

  // advance everything unless a finished result waits
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  pfp_cross #(.CW(CW)) u_cross (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .valid_i      (in_valid_i),
    .p1_i         ({p1_z_i, p1_y_i, p1_x_i}),
    .p2_i         ({p2_z_i, p2_y_i, p2_x_i}),
    .p3_i         ({p3_z_i, p3_y_i, p3_x_i}),
    .min_len_sq_i (min_len_sq_q),
    .valid_o      (x_valid),
    .sq_o         (x_sq),
    .cneg_o       (x_cneg),
    .s_o          (x_s),
    .coll_o       (x_coll),
    .p3_o         (x_p3)
  );

  pfp_normal #(.CW(CW), .F(F)) u_normal (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (x_valid),
    .sq_i    (x_sq),
    .cneg_i  (x_cneg),
    .s_i     (x_s),
    .coll_i  (x_coll),
    .p3_i    (x_p3),
    .valid_o (u_valid),
    .n_o     (u_n),
    .coll_o  (u_coll),
    .p3_o    (u_p3)
  );

  pfp_offset #(.CW(CW), .F(F)) u_offset (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (u_valid),
    .n_i     (u_n),
    .p3_i    (u_p3),
    .coll_i  (u_coll),
    .valid_o (out_valid_o),
    .n_o     (o_n),
    .d_o     (o_d),
    .coll_o  (collinear_o)
  );

  assign normal_x_o = o_n[0];
  assign normal_y_o = o_n[1];
  assign normal_z_o = o_n[2];
  assign offset_d_o = o_d;

endmodule

/* sv/pfp_cross.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfp_cross
// Edge vectors, exact cross product, squared components and squared length,
// and the collinearity compare. Eight register stages.
// ----------------------------------------------------------------------------
module pfp_cross #(
  parameter int unsigned CW = pfp_pkg::COORD_WIDTH_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         adv_i,
  input  logic                                         valid_i,
  input  logic [2:0][CW-1:0]                           p1_i,
  input  logic [2:0][CW-1:0]                           p2_i,
  input  logic [2:0][CW-1:0]                           p3_i,
  input  logic [pfp_pkg::CFG_WIDTH-1:0]                min_len_sq_i,
  output logic                                         valid_o,
  output logic [2:0][2*pfp_pkg::mag_width(CW)-1:0]     sq_o,
  output logic [2:0]                                   cneg_o,
  output logic [pfp_pkg::sum_width(CW)-1:0]            s_o,
  output logic                                         coll_o,
  output logic [2:0][CW-1:0]                           p3_o
);

  localparam int unsigned EW  = CW + 1;
  localparam int unsigned PW  = 2 * EW;
  localparam int unsigned MW  = pfp_pkg::mag_width(CW);
  localparam int unsigned LW  = MW / 2;
  localparam int unsigned HW  = MW - LW;
  localparam int unsigned QW  = 2 * MW;
  localparam int unsigned SW  = pfp_pkg::sum_width(CW);
  localparam int unsigned NST = 8;
  localparam int unsigned CFW = pfp_pkg::CFG_WIDTH;

  logic [NST-1:0]        vld_q;
  logic [2:0][CW-1:0]    p3_q [NST];

  logic signed [EW-1:0]  e1_d [3], e1_q [3];
  logic signed [EW-1:0]  e2_d [3], e2_q [3];
  logic signed [PW-1:0]  m_q [6];
  logic signed [PW:0]    c_q [3];
  logic signed [PW:0]    cn [3];
  logic [MW-1:0]         mag_q [3];
  logic [2:0]            cneg4_q, cneg5_q, cneg6_q, cneg7_q, cneg8_q;
  logic [2*HW-1:0]       hh_q [3];
  logic [HW+LW-1:0]      hl_q [3];
  logic [2*LW-1:0]       ll_q [3];
  logic [QW-1:0]         sq6_q [3], sq7_q [3], sq8_q [3];
  logic [SW-1:0]         s7_q, s8_q;
  logic                  coll_q;

  // advance the valid line with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[NST-2:0], valid_i};
    end
  end

  // form the edge vectors
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      e1_d[l] = $signed({p1_i[l][CW-1], p1_i[l]}) - $signed({p2_i[l][CW-1], p2_i[l]});
      e2_d[l] = $signed({p2_i[l][CW-1], p2_i[l]}) - $signed({p3_i[l][CW-1], p3_i[l]});
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      cn[l] = -c_q[l];
    end
  end

  // pipeline payload, held on stall
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p3_q[0] <= p3_i;
      for (int k = 1; k < NST; k++) begin
        p3_q[k] <= p3_q[k-1];
      end
      // stage 1: differences
      for (int l = 0; l < 3; l++) begin
        e1_q[l] <= e1_d[l];
        e2_q[l] <= e2_d[l];
      end
      // stage 2: cross-product terms
      m_q[0] <= PW'(e1_q[1]) * PW'(e2_q[2]);
      m_q[1] <= PW'(e1_q[2]) * PW'(e2_q[1]);
      m_q[2] <= PW'(e1_q[2]) * PW'(e2_q[0]);
      m_q[3] <= PW'(e1_q[0]) * PW'(e2_q[2]);
      m_q[4] <= PW'(e1_q[0]) * PW'(e2_q[1]);
      m_q[5] <= PW'(e1_q[1]) * PW'(e2_q[0]);
      // stage 3: cross product
      for (int l = 0; l < 3; l++) begin
        c_q[l] <= (PW+1)'(m_q[2*l]) - (PW+1)'(m_q[2*l+1]);
      end
      // stage 4: sign and magnitude
      for (int l = 0; l < 3; l++) begin
        cneg4_q[l] <= c_q[l][PW];
        mag_q[l]   <= c_q[l][PW] ? cn[l][MW-1:0] : c_q[l][MW-1:0];
      end
      // stage 5: partial products of the square
      for (int l = 0; l < 3; l++) begin
        hh_q[l] <= (2*HW)'(mag_q[l][MW-1:LW]) * (2*HW)'(mag_q[l][MW-1:LW]);
        hl_q[l] <= (HW+LW)'(mag_q[l][MW-1:LW]) * (HW+LW)'(mag_q[l][LW-1:0]);
        ll_q[l] <= (2*LW)'(mag_q[l][LW-1:0]) * (2*LW)'(mag_q[l][LW-1:0]);
      end
      cneg5_q <= cneg4_q;
      // stage 6: squares
      for (int l = 0; l < 3; l++) begin
        sq6_q[l] <= (QW'(hh_q[l]) << (2*LW)) + (QW'(hl_q[l]) << (LW+1)) + QW'(ll_q[l]);
      end
      cneg6_q <= cneg5_q;
      // stage 7: squared length
      s7_q    <= SW'(sq6_q[0]) + SW'(sq6_q[1]) + SW'(sq6_q[2]);
      sq7_q   <= sq6_q;
      cneg7_q <= cneg6_q;
      // stage 8: collinearity
      coll_q  <= (s7_q[SW-1:CFW] == '0) && (s7_q[CFW-1:0] <= min_len_sq_i);
      s8_q    <= s7_q;
      sq8_q   <= sq7_q;
      cneg8_q <= cneg7_q;
    end
  end

  assign valid_o = vld_q[NST-1];
  assign s_o     = s8_q;
  assign coll_o  = coll_q;
  assign cneg_o  = cneg8_q;
  assign p3_o    = p3_q[NST-1];
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      sq_o[l] = sq8_q[l];
    end
  end

endmodule

/* sv/pfp_normal.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfp_normal
// Unit normal per component: restoring division c^2 * 4^(F+1) / s, one
// quotient bit a stage, then a digit-by-digit square root, one root bit a
// stage, then rounding, sign and the collinear default.
// ----------------------------------------------------------------------------
module pfp_normal #(
  parameter int unsigned CW = pfp_pkg::COORD_WIDTH_DEF,
  parameter int unsigned F  = pfp_pkg::NORMAL_FRAC_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         adv_i,
  input  logic                                         valid_i,
  input  logic [2:0][2*pfp_pkg::mag_width(CW)-1:0]     sq_i,
  input  logic [2:0]                                   cneg_i,
  input  logic [pfp_pkg::sum_width(CW)-1:0]            s_i,
  input  logic                                         coll_i,
  input  logic [2:0][CW-1:0]                           p3_i,
  output logic                                         valid_o,
  output logic [2:0][F+1:0]                            n_o,
  output logic                                         coll_o,
  output logic [2:0][CW-1:0]                           p3_o
);

  localparam int unsigned SW  = pfp_pkg::sum_width(CW);
  localparam int unsigned QW  = 2 * F + 3;   // quotient bits
  localparam int unsigned DST = QW;          // division stages
  localparam int unsigned RW  = F + 2;       // root bits
  localparam int unsigned RST = RW;          // root stages
  localparam int unsigned XW  = 2 * RW + 1;  // root compare width
  localparam int unsigned NW  = F + 2;
  localparam int unsigned NST = DST + RST + 1;

  logic [NST-1:0]      vld_q;
  logic [2:0]          cneg_q [NST];
  logic                coll_q [NST];
  logic [2:0][CW-1:0]  p3_q [NST];

  logic [SW-1:0]  ds_q   [DST];
  logic [SW-1:0]  drem_q [DST][3];
  logic [QW-1:0]  dquo_q [DST][3];
  logic [SW-1:0]  dsin   [DST];
  logic [SW:0]    dtry   [DST][3];
  logic [QW-1:0]  dqin   [DST][3];
  logic           dge    [DST][3];
  logic [SW:0]    ddif   [DST][3];

  logic [QW-1:0]  srem_q  [RST][3];
  logic [RW-1:0]  sroot_q [RST][3];
  logic [QW-1:0]  srin    [RST][3];
  logic [RW-1:0]  sroin   [RST][3];
  logic [XW-1:0]  sdel    [RST][3];
  logic           sge     [RST][3];
  logic [XW-1:0]  sdif    [RST][3];

  logic [RW:0]    kinc [3];
  logic [NW-1:0]  kval [3];
  logic [NW-1:0]  n_d  [3];
  logic [NW-1:0]  n_q  [3];

  // advance the valid line with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[NST-2:0], valid_i};
    end
  end

  // division: one quotient bit per stage, remainder stays below s
  always_comb begin
    for (int j = 0; j < DST; j++) begin
      dsin[j] = (j == 0) ? s_i : ds_q[(j == 0) ? 0 : j-1];
      for (int l = 0; l < 3; l++) begin
        if (j == 0) begin
          dtry[j][l] = {1'b0, SW'(sq_i[l])};
          dqin[j][l] = '0;
        end else begin
          dtry[j][l] = {drem_q[j-1][l], 1'b0};
          dqin[j][l] = dquo_q[j-1][l];
        end
        dge[j][l]  = dtry[j][l] >= {1'b0, dsin[j]};
        ddif[j][l] = dtry[j][l] - {1'b0, dsin[j]};
      end
    end
  end

  // square root: one root bit per stage
  always_comb begin
    for (int j = 0; j < RST; j++) begin
      for (int l = 0; l < 3; l++) begin
        if (j == 0) begin
          srin[j][l]  = dquo_q[DST-1][l];
          sroin[j][l] = '0;
        end else begin
          srin[j][l]  = srem_q[j-1][l];
          sroin[j][l] = sroot_q[j-1][l];
        end
        sdel[j][l] = (XW'(sroin[j][l]) << (RST - j)) + (XW'(1) << (2 * (RST - 1 - j)));
        sge[j][l]  = XW'(srin[j][l]) >= sdel[j][l];
        sdif[j][l] = XW'(srin[j][l]) - sdel[j][l];
      end
    end
  end

  // round to nearest, apply sign, fall back to (0, 0, 1) when collinear
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      kinc[l] = {1'b0, sroot_q[RST-1][l]} + (RW+1)'(1);
      kval[l] = kinc[l][RW:1];
      if (coll_q[NST-2]) begin
        n_d[l] = (l == 2) ? (NW'(1) << F) : '0;
      end else if (cneg_q[NST-2][l]) begin
        n_d[l] = -kval[l];
      end else begin
        n_d[l] = kval[l];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cneg_q[0] <= cneg_i;
      coll_q[0] <= coll_i;
      p3_q[0]   <= p3_i;
      for (int k = 1; k < NST; k++) begin
        cneg_q[k] <= cneg_q[k-1];
        coll_q[k] <= coll_q[k-1];
        p3_q[k]   <= p3_q[k-1];
      end
      for (int j = 0; j < DST; j++) begin
        ds_q[j] <= dsin[j];
        for (int l = 0; l < 3; l++) begin
          drem_q[j][l] <= dge[j][l] ? ddif[j][l][SW-1:0] : dtry[j][l][SW-1:0];
          dquo_q[j][l] <= {dqin[j][l][QW-2:0], dge[j][l]};
        end
      end
      for (int j = 0; j < RST; j++) begin
        for (int l = 0; l < 3; l++) begin
          srem_q[j][l]  <= sge[j][l] ? sdif[j][l][QW-1:0] : srin[j][l];
          sroot_q[j][l] <= sroin[j][l] | (RW'(sge[j][l]) << (RST - 1 - j));
        end
      end
      for (int l = 0; l < 3; l++) begin
        n_q[l] <= n_d[l];
      end
    end
  end

  assign valid_o = vld_q[NST-1];
  assign coll_o  = coll_q[NST-1];
  assign p3_o    = p3_q[NST-1];
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      n_o[l] = n_q[l];
    end
  end

endmodule

/* sv/pfp_offset.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfp_offset
// Plane offset d = -(p3 . n), rounded back to the coordinate format and
// saturated. Five register stages; the last one is the output register.
// ----------------------------------------------------------------------------
module pfp_offset #(
  parameter int unsigned CW = pfp_pkg::COORD_WIDTH_DEF,
  parameter int unsigned F  = pfp_pkg::NORMAL_FRAC_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  valid_i,
  input  logic [2:0][F+1:0]     n_i,
  input  logic [2:0][CW-1:0]    p3_i,
  input  logic                  coll_i,
  output logic                  valid_o,
  output logic [2:0][F+1:0]     n_o,
  output logic [CW:0]           d_o,
  output logic                  coll_o
);

  localparam int unsigned NW  = F + 2;
  localparam int unsigned PRW = CW + NW;
  localparam int unsigned TW  = PRW + 2;
  localparam int unsigned RDW = TW + 1 - F;
  localparam int unsigned DW  = CW + 1;
  localparam int unsigned NST = 5;

  logic [NST-1:0]          vld_q;
  logic [2:0][F+1:0]       n_q [NST];
  logic                    coll_q [NST];

  logic signed [PRW-1:0]   prod_q [3];
  logic signed [TW-1:0]    sum_q;
  logic signed [TW-1:0]    sum_n;
  logic                    neg3_q, neg4_q;
  logic [TW-1:0]           mag_q;
  logic [TW:0]             rnd;
  logic [RDW-1:0]          r_q;
  logic [RDW-1:0]          lim;
  logic [RDW-1:0]          sat;
  logic [DW-1:0]           d_d, d_q;

  // advance the valid line with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[NST-2:0], valid_i};
    end
  end

  always_comb begin
    sum_n = -sum_q;
    rnd   = {1'b0, mag_q} + ((TW+1)'(1) << (F - 1));
    lim   = (RDW'(1) << (DW - 1)) - RDW'(!neg4_q);
    sat   = (r_q > lim) ? lim : r_q;
    d_d   = neg4_q ? -sat[DW-1:0] : sat[DW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      n_q[0]    <= n_i;
      coll_q[0] <= coll_i;
      for (int k = 1; k < NST; k++) begin
        n_q[k]    <= n_q[k-1];
        coll_q[k] <= coll_q[k-1];
      end
      // stage 1: products
      for (int l = 0; l < 3; l++) begin
        prod_q[l] <= PRW'($signed(p3_i[l])) * PRW'($signed(n_i[l]));
      end
      // stage 2: dot product
      sum_q  <= TW'(prod_q[0]) + TW'(prod_q[1]) + TW'(prod_q[2]);
      // stage 3: d is negative exactly when the dot product is positive
      neg3_q <= !sum_q[TW-1] && (sum_q != '0);
      mag_q  <= sum_q[TW-1] ? sum_n : sum_q;
      // stage 4: round half away from zero
      neg4_q <= neg3_q;
      r_q    <= rnd[TW:F];
      // stage 5: saturate and restore the sign
      d_q    <= d_d;
    end
  end

  assign valid_o = vld_q[NST-1];
  assign n_o     = n_q[NST-1];
  assign coll_o  = coll_q[NST-1];
  assign d_o     = d_q;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for plane_from_three_points_core. Triangles are sent
// on the request channel with random gaps while the result channel stalls at
// random. Every accepted request is run through a bit-exact plane predictor
// (exact cross product, rounded Q2.30 normal, rounded Q17.16 offset) and the
// result is compared field by field in order. Collinearity threshold phases:
// zero, powers of two, a random value, all ones, squared lengths and one less.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CW        = pfp_pkg::COORD_WIDTH_DEF;
  localparam int unsigned FRAC      = pfp_pkg::NORMAL_FRAC_DEF;
  localparam int unsigned STALL_MAX = 5000;

  typedef logic signed [255:0] wide_t;
  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t p[9];
  } triangle_t;

  typedef struct {
    logic signed [FRAC+1:0] nx;
    logic signed [FRAC+1:0] ny;
    logic signed [FRAC+1:0] nz;
    logic signed [CW:0]     d;
    logic                   coll;
  } plane_t;

  typedef enum int {
    GEN_FULL, GEN_EXTREME, GEN_SMALL, GEN_LINE, GEN_NEAR_LINE
  } gen_kind_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [pfp_pkg::CFG_WIDTH-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  coord_t pin[9] = '{default: '0};
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [FRAC+1:0] normal_x, normal_y, normal_z;
  logic signed [CW:0] offset_d;
  logic collinear;

  logic [63:0] threshold = '0;
  plane_t plane_q[$];
  int unsigned err_cnt = 0;
  bit idle_on = 1'b1;
  int unsigned quiet_cycles = 0;
  int unsigned ready_hold = 0;

  plane_from_three_points_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_min_len_sq_i(cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .p1_x_i          (pin[0]),
    .p1_y_i          (pin[1]),
    .p1_z_i          (pin[2]),
    .p2_x_i          (pin[3]),
    .p2_y_i          (pin[4]),
    .p2_z_i          (pin[5]),
    .p3_x_i          (pin[6]),
    .p3_y_i          (pin[7]),
    .p3_z_i          (pin[8]),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .normal_x_o      (normal_x),
    .normal_y_o      (normal_y),
    .normal_z_o      (normal_z),
    .offset_d_o      (offset_d),
    .collinear_o     (collinear)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // exact cross product of the edge vectors p1 - p2 and p2 - p3
  function automatic void cross_of(triangle_t t, output wide_t c[3]);
    wide_t a[3], b[3];
    for (int i = 0; i < 3; i++) begin
      a[i] = wide_t'(t.p[i]) - wide_t'(t.p[3+i]);
      b[i] = wide_t'(t.p[3+i]) - wide_t'(t.p[6+i]);
    end
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic logic [255:0] len_sq(triangle_t t);
    wide_t c[3];
    cross_of(t, c);
    return c[0] * c[0] + c[1] * c[1] + c[2] * c[2];
  endfunction

  function automatic plane_t plane_of(triangle_t t);
    wide_t c[3];
    wide_t acc;
    wide_t n[3];
    logic [255:0] s, rhs, odd, mag, lim;
    logic [63:0] k, cand;
    logic neg;
    plane_t r;
    cross_of(t, c);
    s = len_sq(t);
    r.coll = (s <= {192'd0, threshold});
    if (r.coll) begin
      n[0] = 0;
      n[1] = 0;
      n[2] = wide_t'(1) <<< FRAC;
    end else begin
      // bisect the largest k with (2k-1)^2 * s <= (c * 2^(F+1))^2
      for (int i = 0; i < 3; i++) begin
        rhs = (c[i] * c[i]) << (2 * FRAC + 2);
        k = '0;
        for (int bt = FRAC; bt >= 0; bt--) begin
          cand = k | (64'd1 << bt);
          odd = 256'(2 * cand - 1);
          if (odd * odd * s <= rhs) k = cand;
        end
        n[i] = (c[i] < 0) ? -wide_t'(k) : wide_t'(k);
      end
    end
    acc = 0;
    for (int i = 0; i < 3; i++) acc = acc + wide_t'(t.p[6+i]) * n[i];
    acc = -acc;
    neg = acc < 0;
    mag = neg ? -acc : acc;
    mag = (mag + (256'd1 << (FRAC - 1))) >> FRAC;
    lim = neg ? (256'd1 << CW) : ((256'd1 << CW) - 1);
    if (mag > lim) mag = lim;
    r.d = neg ? -mag[CW:0] : mag[CW:0];
    r.nx = n[0][FRAC+1:0];
    r.ny = n[1][FRAC+1:0];
    r.nz = n[2][FRAC+1:0];
    return r;
  endfunction

  function automatic coord_t pick_coord(bit extreme);
    if (!extreme) return coord_t'($urandom);
    case ($urandom_range(0, 6))
      0: return {1'b0, {(CW-1){1'b1}}};
      1: return {1'b1, {(CW-1){1'b0}}};
      2: return '0;
      3: return '1;
      4: return coord_t'(1);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic triangle_t make_triangle(gen_kind_e kind);
    triangle_t t;
    coord_t base[3], dir[3];
    int k2, k3;
    case (kind)
      GEN_FULL, GEN_EXTREME:
        for (int i = 0; i < 9; i++) t.p[i] = pick_coord(kind == GEN_EXTREME);
      GEN_SMALL:
        for (int i = 0; i < 9; i++) t.p[i] = coord_t'($urandom_range(0, 8192)) - 4096;
      default: begin
        // points along one line, optionally nudged off by one unit
        k2 = int'($urandom_range(0, 128)) - 64;
        k3 = int'($urandom_range(0, 128)) - 64;
        for (int i = 0; i < 3; i++) begin
          base[i] = coord_t'($urandom_range(0, 1 << 21)) - (1 << 20);
          dir[i]  = coord_t'($urandom_range(0, 512)) - 256;
          t.p[i]   = base[i];
          t.p[3+i] = base[i] + dir[i] * k2;
          t.p[6+i] = base[i] + dir[i] * k3;
        end
        if (kind == GEN_NEAR_LINE) begin
          t.p[$urandom_range(0, 8)] += ($urandom_range(0, 1) ? 1 : -1);
        end
      end
    endcase
    return t;
  endfunction

  // send one triangle request and record its expected plane
  task automatic send_triangle(triangle_t t);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    for (int i = 0; i < 9; i++) pin[i] <= t.p[i];
    do @(posedge clk_i); while (!in_ready);
    plane_q.push_back(plane_of(t));
  endtask

  task automatic send_kind(gen_kind_e kind, int unsigned count);
    repeat (count) send_triangle(make_triangle(kind));
  endtask

  // drain and write the threshold while the core is idle
  task automatic write_threshold(logic [63:0] value);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (plane_q.size() != 0) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    threshold = value;
  endtask

  task automatic test_directed();
    triangle_t t;
    // axis-aligned triangles in both windings and one diagonal plane
    t.p = '{0, 0, 0, 65536, 0, 0, 0, 65536, 0};
    send_triangle(t);
    t.p = '{0, 65536, 0, 65536, 0, 0, 0, 0, 65536};
    send_triangle(t);
    t.p = '{0, 0, 5, 0, 65536, 5, 65536, 0, 5};
    send_triangle(t);
    // all three points equal
    t.p = '{7, 7, 7, 7, 7, 7, 7, 7, 7};
    send_triangle(t);
    // x and y on one line, third point with negative z
    t.p = '{0, 0, 0, 1, 1, 1, 2, 2, -123456};
    send_triangle(t);
    t.p = '{1, 1, 1, 2, 2, 2, 3, 3, -9};
    send_triangle(t);
    // coordinates at the ends of the range
    t.p = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
            32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000};
    send_triangle(t);
    t.p = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000,
            32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff};
    send_triangle(t);
    t.p = '{32'h7fffffff, 0, 0, 0, 32'h7fffffff, 0, 0, 0, 32'h7fffffff};
    send_triangle(t);
    t.p = '{32'h80000000, 0, 0, 0, 32'h80000000, 0, 0, 0, 32'h80000000};
    send_triangle(t);
    // tiny diagonal planes
    t.p = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
    send_triangle(t);
    t.p = '{-1, 0, 0, 0, -1, 0, 0, 0, -1};
    send_triangle(t);
    send_kind(GEN_EXTREME, 8);
  endtask

  // threshold exactly at and just below the squared length
  task automatic test_threshold_edges();
    triangle_t t;
    logic [255:0] s;
    for (int n = 0; n < 6; n++) begin
      t = make_triangle(n < 3 ? GEN_SMALL : GEN_NEAR_LINE);
      s = len_sq(t);
      if (s == 0 || s > 256'({64{1'b1}})) continue;
      write_threshold(s[63:0]);
      send_triangle(t);
      write_threshold(s[63:0] - 1);
      send_triangle(t);
    end
  endtask

  task automatic test_threshold_sweep();
    logic [63:0] levels[5];
    levels = '{64'd0, 64'd1 << 40, {$urandom, $urandom}, 64'd1 << 62, '1};
    foreach (levels[i]) begin
      write_threshold(levels[i]);
      for (int n = 0; n < 60; n++) send_triangle(make_triangle(gen_kind_e'($urandom_range(0, 4))));
    end
  endtask

  task automatic test_random_stream();
    write_threshold(64'd1 << 30);
    for (int n = 0; n < 1380; n++) begin
      if (n == 1100) idle_on = 1'b0;
      case ($urandom_range(0, 9))
        0, 1, 2: send_kind(GEN_FULL, 1);
        3:       send_kind(GEN_EXTREME, 1);
        4, 5:    send_kind(GEN_SMALL, 1);
        6, 7:    send_kind(GEN_LINE, 1);
        default: send_kind(GEN_NEAR_LINE, 1);
      endcase
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_threshold_edges();
    test_threshold_sweep();
    test_random_stream();
    in_valid <= 1'b0;
    while (plane_q.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // drop result ready in random bursts
  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      ready_hold <= $urandom_range(0, 3);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // compare each result with the oldest expected plane
  always @(posedge clk_i) begin
    plane_t e;
    if (rst_ni && out_valid && out_ready) begin
      if (plane_q.size() == 0) begin
        $error("result without a pending request");
        err_cnt++;
      end else begin
        e = plane_q.pop_front();
        if (normal_x !== e.nx) begin
          $error("normal_x expected %0d actual %0d", e.nx, normal_x);
          err_cnt++;
        end
        if (normal_y !== e.ny) begin
          $error("normal_y expected %0d actual %0d", e.ny, normal_y);
          err_cnt++;
        end
        if (normal_z !== e.nz) begin
          $error("normal_z expected %0d actual %0d", e.nz, normal_z);
          err_cnt++;
        end
        if (offset_d !== e.d) begin
          $error("offset_d expected %0d actual %0d", e.d, offset_d);
          err_cnt++;
        end
        if (collinear !== e.coll) begin
          $error("collinear expected %0d actual %0d", e.coll, collinear);
          err_cnt++;
        end
      end
    end
  end

  // end the run when no handshake completes for too long
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_MAX) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

/* files.f */
sv/pfp_pkg.sv
sv/pfp_cross.sv
sv/pfp_normal.sv
sv/pfp_offset.sv
sv/plane_from_three_points_core.sv
tb/testbench.sv
